// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only outside reset
`define ILE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define ILE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ile_pkg.sv =====
// package for the indexed list engine: sizes, action codes, request/response types
// no dependencies; the rtl modules use it through scoped names, the testbench imports it
package ile_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int CNT_W    = 7;
  localparam int ACT_W    = 4;

  // action codes
  localparam logic [ACT_W-1:0] ACT_INSERT_AT   = 4'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT_HEAD = 4'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT_END  = 4'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE_AT   = 4'd3;
  localparam logic [ACT_W-1:0] ACT_REMOVE_HEAD = 4'd4;
  localparam logic [ACT_W-1:0] ACT_REMOVE_END  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_READ        = 4'd6;
  localparam logic [ACT_W-1:0] ACT_WRITE       = 4'd7;
  localparam logic [ACT_W-1:0] ACT_CLEAR       = 4'd8;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         count;
  } out_rsp_t;

  // broadcast command to the row of cells
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic              rd_en;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== hdl/ile_cell.sv =====
// one list slot: holds an entry, shifts with its neighbors on insert/remove
// depends on ile_pkg
module ile_cell (
  input  logic                      clk,
  input  logic [ile_pkg::POS_W-1:0] cell_idx,
  input  ile_pkg::cell_cmd_t        cmd,
  input  logic [ile_pkg::DATA_W-1:0] left_data,
  input  logic [ile_pkg::DATA_W-1:0] right_data,
  output logic [ile_pkg::DATA_W-1:0] data,
  output logic [ile_pkg::DATA_W-1:0] rd_tap
);

  logic [ile_pkg::DATA_W-1:0] data_r;
  logic [ile_pkg::DATA_W-1:0] data_nxt;
  logic                       at_pos;
  logic                       above_pos;

  assign at_pos    = (cell_idx == cmd.pos);
  assign above_pos = (cell_idx > cmd.pos);

  // next entry: shift up from the left, down from the right, or load
  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      ile_pkg::CELL_INSERT: begin
        if (above_pos) begin
          data_nxt = left_data;
        end else if (at_pos) begin
          data_nxt = cmd.value;
        end
      end
      ile_pkg::CELL_REMOVE: begin
        if (above_pos || at_pos) begin
          data_nxt = right_data;
        end
      end
      ile_pkg::CELL_WRITE: begin
        if (at_pos) begin
          data_nxt = cmd.value;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data   = data_r;
  // read tap is zero unless this slot is addressed
  assign rd_tap = (cmd.rd_en && at_pos) ? data_r : '0;

endmodule

// ===== hdl/ile_ctrl.sv =====
// request decode, length register and registered response for the list engine
// depends on ile_pkg
module ile_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  ile_pkg::in_req_t           in_req,
  input  logic [ile_pkg::DATA_W-1:0] rd_data,
  output logic                       busy,
  output ile_pkg::cell_cmd_t         cmd,
  output logic                       out_strobe,
  output ile_pkg::out_rsp_t          out_rsp
);

  logic                      busy_r;
  logic                      strobe_r;
  logic [ile_pkg::CNT_W-1:0] len_r;
  logic [ile_pkg::CNT_W-1:0] len_nxt;
  ile_pkg::out_rsp_t         rsp_r;
  ile_pkg::out_rsp_t         rsp_nxt;
  logic                      accept;
  logic                      full;
  logic                      empty;
  logic                      ok;
  logic [ile_pkg::POS_W-1:0] last_pos;

  assign accept   = start && !busy_r;
  assign full     = (len_r == ile_pkg::CNT_W'(ile_pkg::CAPACITY));
  assign empty    = (len_r == '0);
  assign last_pos = len_r - 1'b1;

  // decode the request into a cell command and the new length
  always_comb begin
    cmd       = '0;
    cmd.op    = ile_pkg::CELL_HOLD;
    cmd.value = in_req.value;
    cmd.pos   = in_req.position;
    ok        = 1'b0;
    len_nxt   = len_r;
    unique case (in_req.action)
      ile_pkg::ACT_INSERT_AT, ile_pkg::ACT_INSERT_HEAD, ile_pkg::ACT_INSERT_END: begin
        if (in_req.action == ile_pkg::ACT_INSERT_HEAD) begin
          cmd.pos = '0;
        end else if (in_req.action == ile_pkg::ACT_INSERT_END) begin
          cmd.pos = len_r;
        end
        ok = !full && (cmd.pos <= len_r);
        if (ok) begin
          cmd.op  = ile_pkg::CELL_INSERT;
          len_nxt = len_r + 1'b1;
        end
      end
      ile_pkg::ACT_REMOVE_AT, ile_pkg::ACT_REMOVE_HEAD, ile_pkg::ACT_REMOVE_END: begin
        if (in_req.action == ile_pkg::ACT_REMOVE_HEAD) begin
          cmd.pos = '0;
        end else if (in_req.action == ile_pkg::ACT_REMOVE_END) begin
          cmd.pos = last_pos;
        end
        ok = !empty && (cmd.pos < len_r);
        if (ok) begin
          cmd.op  = ile_pkg::CELL_REMOVE;
          len_nxt = last_pos;
        end
      end
      ile_pkg::ACT_READ: begin
        ok        = (in_req.position < len_r);
        cmd.rd_en = ok;
      end
      ile_pkg::ACT_WRITE: begin
        ok = (in_req.position < len_r);
        if (ok) begin
          cmd.op = ile_pkg::CELL_WRITE;
        end
      end
      ile_pkg::ACT_CLEAR: begin
        ok = !empty;
        if (ok) begin
          len_nxt = '0;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    // nothing moves without an accepted request
    if (!accept) begin
      cmd.op    = ile_pkg::CELL_HOLD;
      cmd.rd_en = 1'b0;
      len_nxt   = len_r;
    end
  end

  // response contents
  always_comb begin
    rsp_nxt.ok         = ok;
    rsp_nxt.read_value = rd_data;
    rsp_nxt.count      = len_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      strobe_r <= 1'b0;
      len_r    <= '0;
    end else begin
      busy_r   <= 1'b0;
      strobe_r <= accept;
      len_r    <= len_nxt;
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;
  assign out_rsp    = rsp_r;

endmodule

// ===== hdl/indexed_list_engine.sv =====
// top level of the indexed list engine: control plus a row of list cells
// depends on ile_pkg, ile_ctrl, ile_cell
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+-------------------------------------
//  request  | start, busy, in_req      | taken at an edge with start && !busy
//  response | out_strobe, out_rsp      | one cycle wide, cannot be held off
//
// every request is applied at its accepting edge; its response strobes the next cycle
// a new request can be taken every cycle while busy is low, since all cells shift in parallel
// reset holds busy high and clears the length; cells keep stale data
// entries beyond the length are never read back
module indexed_list_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ile_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output ile_pkg::out_rsp_t out_rsp
);

  ile_pkg::cell_cmd_t         cmd;
  logic [ile_pkg::DATA_W-1:0] cell_data [ile_pkg::CAPACITY];
  logic [ile_pkg::DATA_W-1:0] cell_tap  [ile_pkg::CAPACITY];
  logic [ile_pkg::DATA_W-1:0] rd_data;

  ile_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_req     (in_req),
    .rd_data    (rd_data),
    .busy       (busy),
    .cmd        (cmd),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

  // row of cells, each wired to its two neighbors
  for (genvar i = 0; i < ile_pkg::CAPACITY; i++) begin : g_cell
    logic [ile_pkg::DATA_W-1:0] left_data;
    logic [ile_pkg::DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end

    if (i == ile_pkg::CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    ile_cell u_cell (
      .clk        (clk),
      .cell_idx   (ile_pkg::POS_W'(i)),
      .cmd        (cmd),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .rd_tap     (cell_tap[i])
    );
  end

  // only the addressed cell drives a nonzero tap
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < ile_pkg::CAPACITY; i++) begin
      rd_data = rd_data | cell_tap[i];
    end
  end

endmodule

// ===== hdl/ile_checker.sv =====
// port-level checks for the indexed list engine, bound to the top level
// depends on ile_pkg and assert_macros.svh
`include "assert_macros.svh"

module ile_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input ile_pkg::in_req_t  in_req,
  input logic              out_strobe,
  input ile_pkg::out_rsp_t out_rsp
);

  // every accepted request answers on the next cycle
  `ILE_ASSERT(a_rsp_follows_req, clk, rst_n, (start && !busy) |=> out_strobe, "missing response")

  // no response without a request
  `ILE_ASSERT(a_no_spurious_rsp, clk, rst_n, !(start && !busy) |=> !out_strobe, "extra response")

  // no response right after reset
  `ILE_ASSERT_ALWAYS(a_quiet_after_reset, clk, !rst_n |=> !out_strobe, "response after reset")

  // reported length never exceeds the capacity
  `ILE_ASSERT(a_count_bound, clk, rst_n,
    out_strobe |-> (out_rsp.count <= ile_pkg::CNT_W'(ile_pkg::CAPACITY)), "count over capacity")

  // a failed request reads back zero
  `ILE_ASSERT(a_fail_zero, clk, rst_n,
    (out_strobe && !out_rsp.ok) |-> (out_rsp.read_value == '0), "data on failed request")

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_req     (in_req),
  .out_strobe (out_strobe),
  .out_rsp    (out_rsp)
);

// ===== tb/testbench.sv =====
// testbench for indexed_list_engine: directed and random list requests checked
// against a behavioral list model kept in the bench; depends on ile_pkg and the rtl
module testbench;
  import ile_pkg::*;

  localparam int MAX_PRINTS = 60;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  in_req_t  in_req = '0;
  logic     busy;
  logic     out_strobe;
  out_rsp_t out_rsp;

  // list model state
  logic signed [DATA_W-1:0] list_model [CAPACITY];
  int                       list_len;

  // responses still owed by the block, oldest first
  out_rsp_t pending_rsp [$];
  int       error_count;
  int       print_count;
  // random walk direction: 1 favors inserts, 0 favors removes
  bit       grow_bias;

  indexed_list_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (print_count < MAX_PRINTS) begin
      print_count++;
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  // shift entries up and place the value, unless full or past the end
  function automatic bit list_insert(input int pos, input logic signed [DATA_W-1:0] v);
    if (list_len >= CAPACITY || pos > list_len) return 1'b0;
    for (int k = list_len; k > pos; k--) list_model[k] = list_model[k-1];
    list_model[pos] = v;
    list_len++;
    return 1'b1;
  endfunction

  // shift later entries down over the removed one
  function automatic bit list_remove(input int pos);
    if (pos >= list_len) return 1'b0;
    for (int k = pos; k + 1 < list_len; k++) list_model[k] = list_model[k+1];
    list_len--;
    return 1'b1;
  endfunction

  // apply one request to the model and return the response it should give
  function automatic out_rsp_t predict_response(input in_req_t req);
    out_rsp_t rsp;
    int       pos;
    rsp = '0;
    pos = int'(req.position);
    case (req.action)
      ACT_INSERT_AT:   rsp.ok = list_insert(pos, req.value);
      ACT_INSERT_HEAD: rsp.ok = list_insert(0, req.value);
      ACT_INSERT_END:  rsp.ok = list_insert(list_len, req.value);
      ACT_REMOVE_AT:   rsp.ok = list_remove(pos);
      ACT_REMOVE_HEAD: rsp.ok = list_remove(0);
      ACT_REMOVE_END:  rsp.ok = (list_len > 0) ? list_remove(list_len - 1) : 1'b0;
      ACT_READ: begin
        if (pos < list_len) begin
          rsp.ok = 1'b1;
          rsp.read_value = list_model[pos];
        end
      end
      ACT_WRITE: begin
        if (pos < list_len) begin
          rsp.ok = 1'b1;
          list_model[pos] = req.value;
        end
      end
      ACT_CLEAR: begin
        if (list_len > 0) begin
          rsp.ok = 1'b1;
          list_len = 0;
        end
      end
      default: rsp.ok = 1'b0;
    endcase
    rsp.count = CNT_W'(list_len);
    return rsp;
  endfunction

  function automatic in_req_t make_req(input logic [ACT_W-1:0] act, input int pos,
                                       input logic signed [DATA_W-1:0] v);
    in_req_t req;
    req.action   = act;
    req.position = POS_W'(pos);
    req.value    = v;
    return req;
  endfunction

  // send one request after an optional gap; predict it at the accepting edge
  task automatic send_request(input in_req_t req, input int idle_pct);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(predict_response(req));
  endtask

  // check every response against the oldest prediction
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_strobe) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp.ok !== want.ok)
          report_mismatch($sformatf("ok %0b, expected %0b", out_rsp.ok, want.ok));
        if (out_rsp.read_value !== want.read_value)
          report_mismatch($sformatf("read_value %0d, expected %0d",
                                    out_rsp.read_value, want.read_value));
        if (out_rsp.count !== want.count)
          report_mismatch($sformatf("count %0d, expected %0d", out_rsp.count, want.count));
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // random request shaped by the current length and walk direction
  function automatic in_req_t random_request();
    logic [ACT_W-1:0] act;
    int               pos;
    int               pick;
    pick = $urandom_range(99);
    if (pick < 4) begin
      act = ACT_W'($urandom_range(9, 15));
    end else if (pick < 5) begin
      act = ACT_CLEAR;
    end else if (pick < 50) begin
      act = ACT_W'($urandom_range(0, 2));
      if (!grow_bias && $urandom_range(1)) act = ACT_W'($urandom_range(3, 5));
    end else if (pick < 85) begin
      act = ACT_W'($urandom_range(3, 5));
      if (grow_bias && $urandom_range(1)) act = ACT_W'($urandom_range(0, 2));
    end else begin
      act = $urandom_range(1) ? ACT_READ : ACT_WRITE;
    end
    if ($urandom_range(3) == 0) pos = $urandom_range(0, 127);
    else pos = $urandom_range(0, list_len);
    return make_req(act, pos, random_value());
  endfunction

  // operations on an empty list, bad indexes and unused codes
  task automatic test_empty_list();
    send_request(make_req(ACT_REMOVE_HEAD, 0, 0), 0);
    send_request(make_req(ACT_REMOVE_END, 0, 0), 0);
    send_request(make_req(ACT_REMOVE_AT, 0, 0), 0);
    send_request(make_req(ACT_READ, 0, 0), 0);
    send_request(make_req(ACT_WRITE, 0, 32'sh1234_5678), 0);
    send_request(make_req(ACT_CLEAR, 0, 0), 0);
    send_request(make_req(ACT_INSERT_AT, 1, 32'sd7), 0);
    send_request(make_req(ACT_W'(9), 0, 32'sd1), 0);
    send_request(make_req(ACT_W'(15), 127, -32'sd1), 0);
  endtask

  // extreme values, every operation, and clear on a non-empty then empty list
  task automatic test_edge_values();
    send_request(make_req(ACT_INSERT_HEAD, 0, 32'sh7fff_ffff), 0);
    send_request(make_req(ACT_INSERT_END, 0, 32'sh8000_0000), 0);
    send_request(make_req(ACT_INSERT_AT, 1, 32'sd0), 0);
    send_request(make_req(ACT_INSERT_AT, 0, -32'sd1), 0);
    send_request(make_req(ACT_READ, 0, 0), 0);
    send_request(make_req(ACT_READ, 3, 0), 0);
    send_request(make_req(ACT_WRITE, 3, 32'sh5555_aaaa), 0);
    send_request(make_req(ACT_READ, 3, 0), 0);
    send_request(make_req(ACT_READ, 4, 0), 0);
    send_request(make_req(ACT_READ, 127, 0), 0);
    send_request(make_req(ACT_REMOVE_AT, 1, 0), 0);
    send_request(make_req(ACT_REMOVE_AT, 64, 0), 0);
    send_request(make_req(ACT_REMOVE_END, 0, 0), 0);
    send_request(make_req(ACT_REMOVE_HEAD, 0, 0), 0);
    send_request(make_req(ACT_CLEAR, 0, 0), 0);
    send_request(make_req(ACT_CLEAR, 0, 0), 0);
  endtask

  // fill to capacity, poke at the full list, then drain to empty
  task automatic test_full_list(input int idle_pct);
    logic [ACT_W-1:0] act;
    while (list_len < CAPACITY) begin
      act = ACT_W'($urandom_range(0, 2));
      send_request(make_req(act, $urandom_range(0, list_len), random_value()), idle_pct);
    end
    send_request(make_req(ACT_INSERT_END, 0, random_value()), idle_pct);
    send_request(make_req(ACT_INSERT_HEAD, 0, random_value()), idle_pct);
    send_request(make_req(ACT_INSERT_AT, CAPACITY, random_value()), idle_pct);
    send_request(make_req(ACT_READ, CAPACITY - 1, 0), idle_pct);
    send_request(make_req(ACT_WRITE, CAPACITY - 1, random_value()), idle_pct);
    send_request(make_req(ACT_READ, CAPACITY, 0), idle_pct);
    send_request(make_req(ACT_REMOVE_AT, CAPACITY - 1, 0), idle_pct);
    send_request(make_req(ACT_INSERT_AT, CAPACITY - 1, random_value()), idle_pct);
    while (list_len > 0) begin
      act = ACT_W'($urandom_range(3, 5));
      send_request(make_req(act, $urandom_range(0, list_len - 1), 0), idle_pct);
    end
    send_request(make_req(ACT_REMOVE_END, 0, 0), idle_pct);
  endtask

  // random mix; the walk turns around at the ends or now and then
  task automatic test_random_mix(input int n_items, input int idle_pct);
    for (int k = 0; k < n_items; k++) begin
      if (list_len >= CAPACITY) grow_bias = 1'b0;
      else if (list_len == 0) grow_bias = 1'b1;
      else if ($urandom_range(59) == 0) grow_bias = ~grow_bias;
      send_request(random_request(), idle_pct);
    end
  endtask

  initial begin
    error_count = 0;
    print_count = 0;
    list_len    = 0;
    grow_bias   = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_edge_values();
    test_full_list(0);
    test_random_mix(250, 0);
    test_random_mix(250, 46);
    test_full_list(46);
    test_random_mix(200, 0);
    test_random_mix(250, 21);
    start <= 1'b0;

    // let the last responses drain
    for (int k = 0; k < 200 && pending_rsp.size() > 0; k++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_rsp.size() > 0)
      report_mismatch($sformatf("%0d responses never arrived", pending_rsp.size()));

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ile_pkg.sv
hdl/ile_cell.sv
hdl/ile_ctrl.sv
hdl/indexed_list_engine.sv
hdl/ile_checker.sv
tb/testbench.sv
